[design/multiplexed_servo_pulse_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multiplexed servo pulse sequencer
// Clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SERVO_PULSE_SEQUENCER_ASSERT_SVH
`define MULTIPLEXED_SERVO_PULSE_SEQUENCER_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define MSPS_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle that implies another condition in the next cycle.
`define MSPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/msps_pkg.sv]
// ----------------------------------------------------------------------------
// msps_pkg
// Types and constants shared by the servo pulse sequencer and its testbench.
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int CHANNELS_DEFAULT = 5;

    localparam int POS_W    = 15;
    localparam int GAP_W    = 7;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int LINES_W  = 5;

    localparam logic [POS_W-1:0] POS_RESET     = 15'h0460;
    localparam logic [POS_W-1:0] MIN_POS_RESET = 15'd512;
    localparam logic [POS_W-1:0] MAX_POS_RESET = 15'd2048;
    localparam logic [GAP_W-1:0] GAP_RESET     = 7'd25;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_POSITION = 2'd0,
        CFG_MAX_POSITION = 2'd1,
        CFG_GAP_PERIODS  = 2'd2
    } cfg_idx_t;

endpackage

[design/msps_ram.sv]
// ----------------------------------------------------------------------------
// msps_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 5,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_a_en,
    input  logic [AW-1:0]    rd_a_addr,
    output logic [WIDTH-1:0] rd_a_data,
    input  logic             rd_b_en,
    input  logic [AW-1:0]    rd_b_addr,
    output logic [WIDTH-1:0] rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

[design/multiplexed_servo_pulse_sequencer.sv]
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_sequencer
// Drives CHANNELS servo lines in turn from stored positions, then idles for
// a programmable number of 256-tick periods.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+-------------------------
//  input    | in_valid, in_stall, cmd,         | in_valid && !in_stall
//           | channel, position                |
//  result   | out_valid, out_stall,            | out_valid && !out_stall
//           | servo_lines, read_position       |
//  config   | cfg_we, cfg_index, cfg_data      | cfg_we
//
// One item per cycle while results are not stalled; after its transfer each
// result passes the input register, then the result register, the
// tick/position update being combinational logic on the sequencer state.
// Position RAM reads are registered, issued ahead of use, with write bypass.
// No clearing pass after reset: per-entry valid bits return the reset position.
// A stalled result holds; one further item waits in the input register.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer #(
    parameter int CHANNELS = msps_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [3:0]                      channel,
    input  logic [15:0]                     position,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [msps_pkg::LINES_W-1:0]    servo_lines,
    output logic [msps_pkg::POS_W-1:0]      read_position,

    input  logic                            cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msps_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = $clog2(CHANNELS + 1);
    localparam int LW = CHANNELS + msps_pkg::LINES_W;
    localparam int PS = msps_pkg::POS_W;

    // configuration
    logic [PS-1:0]                  min_pos_reg;
    logic [PS-1:0]                  max_pos_reg;
    logic [msps_pkg::GAP_W-1:0]     gap_reg;

    // input register
    logic                           s1_valid_reg;
    logic [1:0]                     s1_cmd_reg;
    logic [3:0]                     s1_channel_reg;
    logic [15:0]                    s1_position_reg;
    logic                           s1_chan_ok_reg;

    // sequencer state
    logic [7:0]                     fine_reg;
    logic [7:0]                     coarse_reg;
    logic [PW-1:0]                  phase_reg;
    logic [CHANNELS-1:0]            lines_reg;
    logic [CHANNELS-1:0]            vld_reg;

    logic [7:0]                     fine_next;
    logic [7:0]                     coarse_next;
    logic [PW-1:0]                  phase_next;
    logic [CHANNELS-1:0]            lines_next;

    // read-port bypass
    logic                           a_use_byp_reg;
    logic [PS-1:0]                  a_byp_reg;
    logic                           b_use_byp_reg;
    logic [PS-1:0]                  b_byp_reg;

    // result register
    logic                           out_valid_reg;
    logic [msps_pkg::LINES_W-1:0]   out_lines_reg;
    logic [PS-1:0]                  out_read_reg;

    logic                           accept;
    logic                           exec;
    logic                           pop;
    logic                           in_chan_ok;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [PS-1:0]                  wr_data;
    logic [15:0]                    clamp_hi;

    logic [AW-1:0]                  a_addr;
    logic [AW-1:0]                  b_addr;
    logic                           a_hit;
    logic                           b_hit;
    logic [PS-1:0]                  ram_a;
    logic [PS-1:0]                  ram_b;
    logic [PS-1:0]                  pos_a;
    logic [PS-1:0]                  pos_b;

    logic [7:0]                     fine_inc;
    logic [7:0]                     coarse_dec;
    logic [7:0]                     low_byte;
    logic [7:0]                     high_byte;
    logic                           expired;
    logic [PS-1:0]                  rd_value;
    logic [LW-1:0]                  lines_ext;
    msps_pkg::cmd_t                 s1_cmd;

    logic                           rd_unstored;
    logic                           both_full;

    // ---------------- handshake ----------------
    assign pop      = out_valid_reg && !out_stall;
    assign exec     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !exec;
    assign accept   = in_valid && !in_stall;

    assign in_chan_ok = (32'(channel) < CHANNELS);
    assign s1_cmd     = msps_pkg::cmd_t'(s1_cmd_reg);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg <= msps_pkg::MIN_POS_RESET;
            max_pos_reg <= msps_pkg::MAX_POS_RESET;
            gap_reg     <= msps_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (msps_pkg::cfg_idx_t'(cfg_index))
                msps_pkg::CFG_MIN_POSITION: min_pos_reg <= cfg_data;
                msps_pkg::CFG_MAX_POSITION: max_pos_reg <= cfg_data;
                msps_pkg::CFG_GAP_PERIODS:  gap_reg     <= cfg_data[msps_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (exec)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= cmd;
            s1_channel_reg  <= channel;
            s1_position_reg <= position;
            s1_chan_ok_reg  <= in_chan_ok;
        end
    end

    // ---------------- position write path ----------------
    always_comb
    begin
        clamp_hi = s1_position_reg;
        if (s1_position_reg > {1'b0, max_pos_reg})
        begin
            clamp_hi = {1'b0, max_pos_reg};
        end
        if (clamp_hi < {1'b0, min_pos_reg})
        begin
            wr_data = min_pos_reg;
        end
        else
        begin
            wr_data = clamp_hi[PS-1:0];
        end
    end

    assign wr_en   = exec && (s1_cmd == msps_pkg::CMD_WRITE) && s1_chan_ok_reg;
    assign wr_addr = AW'(s1_channel_reg);

    // ---------------- sequencer update ----------------
    assign pos_a      = a_use_byp_reg ? a_byp_reg : ram_a;
    assign pos_b      = b_use_byp_reg ? b_byp_reg : ram_b;
    assign fine_inc   = fine_reg + 8'd1;
    assign coarse_dec = coarse_reg - 8'd1;
    assign expired    = (coarse_dec == 8'd0) || coarse_dec[7];
    assign low_byte   = pos_a[7:0];
    assign high_byte  = {1'b0, pos_a[PS-1:8]};

    always_comb
    begin
        fine_next   = fine_reg;
        coarse_next = coarse_reg;
        phase_next  = phase_reg;
        lines_next  = lines_reg;
        rd_value    = '0;
        case (s1_cmd)
            msps_pkg::CMD_TICK:
            begin
                fine_next = fine_inc;
                if (fine_inc == 8'd0)
                begin
                    coarse_next = coarse_dec;
                    if (expired)
                    begin
                        if (32'(phase_reg) < CHANNELS)
                        begin
                            // start next channel: first period lasts low-byte ticks
                            lines_next = CHANNELS'(1) << phase_reg;
                            phase_next = phase_reg + PW'(1);
                            if (low_byte != 8'd0)
                            begin
                                fine_next   = 8'd0 - low_byte;
                                coarse_next = high_byte;
                            end
                            else
                            begin
                                fine_next   = 8'd0;
                                coarse_next = high_byte - 8'd1;
                            end
                        end
                        else
                        begin
                            phase_next  = '0;
                            lines_next  = '0;
                            coarse_next = {1'b0, gap_reg};
                        end
                    end
                end
            end
            msps_pkg::CMD_READ:
            begin
                if (s1_chan_ok_reg)
                begin
                    rd_value = pos_b;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_reg   <= '0;
            coarse_reg <= 8'd1;
            phase_reg  <= '0;
            lines_reg  <= '0;
            vld_reg    <= '0;
        end
        else if (exec)
        begin
            fine_reg   <= fine_next;
            coarse_reg <= coarse_next;
            phase_reg  <= phase_next;
            lines_reg  <= lines_next;
            if (wr_en)
            begin
                vld_reg <= vld_reg | (CHANNELS'(1) << wr_addr);
            end
        end
    end

    // ---------------- position RAM ----------------
    // Port A prefetches the entry for the phase in force next cycle,
    // port B fetches the entry named by an incoming item.
    assign a_addr = (32'(phase_next) < CHANNELS) ? AW'(phase_next) : '0;
    assign b_addr = in_chan_ok ? AW'(channel) : '0;
    assign a_hit  = wr_en && (wr_addr == a_addr);
    assign b_hit  = wr_en && (wr_addr == b_addr);

    msps_ram #(
        .WIDTH (PS),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_pos_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (exec),
        .rd_a_addr (a_addr),
        .rd_a_data (ram_a),
        .rd_b_en   (accept),
        .rd_b_addr (b_addr),
        .rd_b_data (ram_b)
    );

    // Bypass a same-cycle write, else an unwritten entry reads as reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_use_byp_reg <= 1'b1;
            a_byp_reg     <= msps_pkg::POS_RESET;
            b_use_byp_reg <= 1'b1;
            b_byp_reg     <= msps_pkg::POS_RESET;
        end
        else
        begin
            if (exec)
            begin
                a_use_byp_reg <= a_hit || !vld_reg[a_addr];
                a_byp_reg     <= a_hit ? wr_data : msps_pkg::POS_RESET;
            end
            if (accept)
            begin
                b_use_byp_reg <= b_hit || !vld_reg[b_addr];
                b_byp_reg     <= b_hit ? wr_data : msps_pkg::POS_RESET;
            end
        end
    end

    // ---------------- result register ----------------
    assign lines_ext = LW'(lines_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_lines_reg <= lines_ext[msps_pkg::LINES_W-1:0];
            out_read_reg  <= rd_value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign servo_lines   = out_lines_reg;
    assign read_position = out_read_reg;

    // ---------------- assertions ----------------
    assign rd_unstored = exec && (s1_cmd == msps_pkg::CMD_READ) && !s1_chan_ok_reg;
    assign both_full   = s1_valid_reg && out_valid_reg && out_stall;

`include "multiplexed_servo_pulse_sequencer_assert.svh"

    `MSPS_ASSERT_ALWAYS(a_lines_onehot, $onehot0(lines_reg), "more than one servo line high")
    `MSPS_ASSERT_ALWAYS(a_phase_range, (32'(phase_reg) <= CHANNELS), "phase out of range")
    `MSPS_ASSERT_NEXT(a_read_unstored, rd_unstored, (read_position == '0), "stray read data")
    `MSPS_ASSERT_ALWAYS(a_hold_full, (!both_full || in_stall), "input taken while full")

endmodule

[tb/multiplexed_servo_pulse_sequencer_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo pulse sequencer checker
// Watches the input, result and register ports of the sequencer, keeps its
// own copy of the timer, channel and position state, and compares every
// result transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer_check #(
    parameter int CHANNELS = msps_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [3:0]                      channel,
    input  logic [15:0]                     position,

    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [msps_pkg::LINES_W-1:0]    servo_lines,
    input  logic [msps_pkg::POS_W-1:0]      read_position,

    input  logic                            cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msps_pkg::CFG_W-1:0]      cfg_data,

    output int                              mismatches,
    output int                              pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [msps_pkg::LINES_W-1:0] lines;
        logic [msps_pkg::POS_W-1:0]   rd;
    } servo_result_t;

    servo_result_t      line_read_q [$];

    logic [msps_pkg::POS_W-1:0]   min_pos;
    logic [msps_pkg::POS_W-1:0]   max_pos;
    logic [msps_pkg::GAP_W-1:0]   gap_len;

    logic [7:0]                   fine_tmr;
    logic signed [7:0]            coarse_cnt;
    int unsigned                  seq_phase;
    logic [msps_pkg::POS_W-1:0]   pos_mem [CHANNELS];
    logic [15:0]                  line_lvl;

    int                 mismatch_cnt = 0;

    assign mismatches = mismatch_cnt;

    initial pending = 0;

    function automatic void reset_sequencer();
        min_pos    = msps_pkg::MIN_POS_RESET;
        max_pos    = msps_pkg::MAX_POS_RESET;
        gap_len    = msps_pkg::GAP_RESET;
        fine_tmr   = 8'd0;
        coarse_cnt = 8'sd1;
        seq_phase  = 0;
        line_lvl   = 16'd0;
        for (int i = 0; i < CHANNELS; i++)
            pos_mem[i] = msps_pkg::POS_RESET;
    endfunction

    // Raise one line and load the counters so the first period lasts low-byte ticks
    function automatic void start_pulse(input int unsigned ch);
        logic [msps_pkg::POS_W-1:0] p;
        p          = pos_mem[ch];
        line_lvl   = 16'd1 << ch;
        coarse_cnt = {1'b0, p[14:8]};
        if (p[7:0] != 8'd0) begin
            fine_tmr = 8'd0 - p[7:0];
        end
        else begin
            fine_tmr   = 8'd0;
            coarse_cnt = coarse_cnt - 8'sd1;
        end
    endfunction

    function automatic void advance_tick();
        fine_tmr = fine_tmr + 8'd1;
        if (fine_tmr == 8'd0) begin
            coarse_cnt = coarse_cnt - 8'sd1;
            if (coarse_cnt == 8'sd0 || coarse_cnt[7]) begin
                if (seq_phase < CHANNELS) begin
                    start_pulse(seq_phase);
                    seq_phase++;
                end
                else begin
                    // all channels done: drop the lines and run the idle gap
                    seq_phase  = 0;
                    line_lvl   = 16'd0;
                    coarse_cnt = {1'b0, gap_len};
                end
            end
        end
    endfunction

    function automatic servo_result_t sequencer_step(input logic [1:0] c,
                                                     input logic [3:0] ch,
                                                     input logic [15:0] p_in);
        servo_result_t res;
        logic [15:0]   p;
        res.rd = '0;
        p      = p_in;
        case (c)
            msps_pkg::CMD_TICK: advance_tick();
            msps_pkg::CMD_WRITE:
            begin
                // max first, then min, so min wins when the clamps cross
                if (p > {1'b0, max_pos})
                    p = {1'b0, max_pos};
                if (p < {1'b0, min_pos})
                    p = {1'b0, min_pos};
                if (ch < CHANNELS)
                    pos_mem[ch] = p[msps_pkg::POS_W-1:0];
            end
            msps_pkg::CMD_READ:
            begin
                if (ch < CHANNELS)
                    res.rd = pos_mem[ch];
            end
            default: ;
        endcase
        res.lines = line_lvl[msps_pkg::LINES_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        servo_result_t got_res;
        servo_result_t want_res;
        if (!rst_n) begin
            reset_sequencer();
            line_read_q.delete();
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    msps_pkg::CFG_MIN_POSITION: min_pos = cfg_data[msps_pkg::POS_W-1:0];
                    msps_pkg::CFG_MAX_POSITION: max_pos = cfg_data[msps_pkg::POS_W-1:0];
                    msps_pkg::CFG_GAP_PERIODS:  gap_len = cfg_data[msps_pkg::GAP_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                line_read_q.push_back(sequencer_step(cmd, channel, position));

            if (out_valid && !out_stall) begin
                got_res.lines = servo_lines;
                got_res.rd    = read_position;
                if (line_read_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: result with none predicted: lines %b read %0d",
                                 $realtime, got_res.lines, got_res.rd);
                end
                else begin
                    want_res = line_read_q.pop_front();
                    if (got_res.lines !== want_res.lines || got_res.rd !== want_res.rd) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display("%0t: mismatch: lines exp %b got %b, read exp %0d got %0d",
                                     $realtime, want_res.lines, got_res.lines,
                                     want_res.rd, got_res.rd);
                    end
                end
            end

            pending <= line_read_q.size();
        end
    end

endmodule

[tb/multiplexed_servo_pulse_sequencer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo pulse sequencer testbench
// Drives ticks, position writes and reads into the sequencer through several
// register settings, with random gaps and result stalls, and reports the
// verdict from the checker's counts and the sent and taken result totals.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer_test;

    localparam int             CHANNELS   = msps_pkg::CHANNELS_DEFAULT;
    localparam int             HANG_LIMIT = 500;
    localparam int             DRAIN_WAIT = 8;
    localparam logic [1:0]     CMD_UNUSED = 2'd3;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;

    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [1:0]                cmd       = msps_pkg::CMD_TICK;
    logic [3:0]                channel   = 4'd0;
    logic [15:0]               position  = 16'd0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [msps_pkg::LINES_W-1:0]    servo_lines;
    logic [msps_pkg::POS_W-1:0]      read_position;

    logic                            cfg_we    = 1'b0;
    logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index = msps_pkg::CFG_MIN_POSITION;
    logic [msps_pkg::CFG_W-1:0]      cfg_data  = '0;

    int                        mismatches;
    int                        pending;
    int                        sent_count = 0;
    int                        got_count  = 0;
    int                        hang_count = 0;
    int                        stall_left = 0;
    bit                        quiet      = 1'b0;

    multiplexed_servo_pulse_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .channel       (channel),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_lines   (servo_lines),
        .read_position (read_position),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    multiplexed_servo_pulse_sequencer_check #(
        .CHANNELS (CHANNELS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .channel       (channel),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_lines   (servo_lines),
        .read_position (read_position),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    // Result stalls come in bursts of random length, with open cycles between
    always @(posedge clk) begin
        if (quiet || !rst_n) begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
        else if (out_stall) begin
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
    end

    // Count result transfers; end the run when nothing moves for too long
    always @(posedge clk) begin
        if (out_valid && !out_stall)
            got_count <= got_count + 1;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                hang_count <= 0;
            end
            else if (hang_count >= HANG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
            else begin
                hang_count <= hang_count + 1;
            end
        end
    end

    task automatic send_item(input logic [1:0] c, input logic [3:0] ch,
                             input logic [15:0] p);
        in_valid <= 1'b1;
        cmd      <= c;
        channel  <= ch;
        position <= p;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (got_count != sent_count)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [msps_pkg::POS_W-1:0] min_p,
                              input logic [msps_pkg::POS_W-1:0] max_p,
                              input logic [msps_pkg::GAP_W-1:0] gap_p);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= msps_pkg::CFG_MIN_POSITION;
        cfg_data  <= min_p;
        @(posedge clk);
        cfg_index <= msps_pkg::CFG_MAX_POSITION;
        cfg_data  <= max_p;
        @(posedge clk);
        cfg_index <= msps_pkg::CFG_GAP_PERIODS;
        cfg_data  <= {{(msps_pkg::CFG_W-msps_pkg::GAP_W){1'b0}}, gap_p};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_spaced(input logic [1:0] c, input logic [3:0] ch,
                               input logic [15:0] p);
        send_item(c, ch, p);
        sender_gap();
    endtask

    // Mostly ticks so the pulse train runs through channels and gaps
    task automatic run_random(input int items, input int pos_hi);
        int          done_n;
        int          pick;
        logic [3:0]  ch;
        logic [15:0] p;
        done_n = 0;
        while (done_n < items) begin
            pick = $urandom_range(0, 99);
            ch   = 4'($urandom_range(0, 15));
            p    = 16'($urandom_range(0, 65535));
            if (pick < 88) begin
                send_item(msps_pkg::CMD_TICK, ch, p);
                done_n++;
            end
            else if (pick < 94) begin
                if ($urandom_range(0, 3) != 0) begin
                    ch = 4'($urandom_range(0, CHANNELS - 1));
                    if ($urandom_range(0, 2) != 0)
                        p = 16'($urandom_range(240, pos_hi));
                end
                send_item(msps_pkg::CMD_WRITE, ch, p);
                if (ch < CHANNELS)
                    done_n++;
            end
            else if (pick < 98) begin
                send_item(msps_pkg::CMD_READ, ch, p);
                done_n++;
            end
            else begin
                send_item(CMD_UNUSED, ch, p);
            end
            if (!quiet && $urandom_range(0, 199) == 0)
                wait_idle();
            sender_gap();
        end
    endtask

    initial begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset clamps, unstored channels, unused command
        send_spaced(msps_pkg::CMD_WRITE, 4'd0, 16'hFFFF);
        send_spaced(msps_pkg::CMD_READ, 4'd0, 16'h0000);
        send_spaced(msps_pkg::CMD_WRITE, 4'd1, 16'h0000);
        send_spaced(msps_pkg::CMD_READ, 4'd1, 16'hFFFF);
        send_spaced(msps_pkg::CMD_WRITE, 4'd15, 16'd1234);
        send_spaced(msps_pkg::CMD_READ, 4'd15, 16'h0000);
        send_spaced(msps_pkg::CMD_READ, 4'd4, 16'h0000);
        send_spaced(CMD_UNUSED, 4'd3, 16'h5555);
        send_spaced(msps_pkg::CMD_TICK, 4'd10, 16'hAAAA);
        send_spaced(msps_pkg::CMD_TICK, 4'd5, 16'h5555);

        // widest clamps
        set_config(15'd0, 15'd32767, 7'd0);
        send_spaced(msps_pkg::CMD_WRITE, 4'd2, 16'h0000);
        send_spaced(msps_pkg::CMD_READ, 4'd2, 16'h0000);
        send_spaced(msps_pkg::CMD_WRITE, 4'd3, 16'hFFFF);
        send_spaced(msps_pkg::CMD_READ, 4'd3, 16'h0000);

        // crossed clamps at the extremes: min wins
        set_config(15'd32767, 15'd256, 7'd127);
        send_spaced(msps_pkg::CMD_WRITE, 4'd0, 16'd100);
        send_spaced(msps_pkg::CMD_READ, 4'd0, 16'h0000);
        send_spaced(msps_pkg::CMD_WRITE, 4'd1, 16'hFFFF);
        send_spaced(msps_pkg::CMD_READ, 4'd1, 16'h0000);

        // short pulses, one below a full period, one of zero, zero gap
        set_config(15'd0, 15'd300, 7'd0);
        send_spaced(msps_pkg::CMD_WRITE, 4'd0, 16'd257);
        send_spaced(msps_pkg::CMD_WRITE, 4'd1, 16'hFFFF);
        send_spaced(msps_pkg::CMD_WRITE, 4'd2, 16'd0);
        send_spaced(msps_pkg::CMD_WRITE, 4'd3, 16'd256);
        send_spaced(msps_pkg::CMD_WRITE, 4'd4, 16'd200);

        set_config(15'd256, 15'd300, 7'd1);
        run_random(120, 300);

        set_config(15'($urandom_range(0, 200)), 15'($urandom_range(257, 330)), 7'd0);
        run_random(120, 330);

        set_config(15'd280, 15'd270, 7'd2);
        run_random(120, 330);

        quiet <= 1'b1;
        set_config(15'd256, 15'd320, 7'd127);
        run_random(120, 320);

        wait_idle();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (mismatches == 0 && pending == 0 && got_count == sent_count)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
